[hdl/ntht_pkg.sv]
// Shared types, constants and the helper function of the name-to-handle table.
package ntht_pkg;

  localparam int DEF_TABLE_DEPTH = 128;
  localparam int DEF_HANDLE_BITS = 8;

  localparam int KEY_W        = 64;
  localparam int KIND_W       = 2;
  localparam int IN_HANDLE_W  = 8;
  localparam int SLOT_W       = 7;
  localparam int OUT_HANDLE_W = 8;
  localparam int IN_TDATA_W   = 80;
  localparam int OUT_TDATA_W  = 16;

  localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd2;

  // Outcome flags of one scan over the table.
  typedef struct packed {
    logic hit_found;
    logic free_found;
  } scan_flags_t;

  // Clear every byte that follows the first zero byte of a name.
  function automatic logic [KEY_W-1:0] norm_key(input logic [KEY_W-1:0] k);
    logic [KEY_W-1:0] res;
    logic             live;
    res  = '0;
    live = 1'b1;
    for (int i = 0; i < 8; i++) begin
      if (k[8*i +: 8] == 8'd0) begin
        live = 1'b0;
      end
      if (live) begin
        res[8*i +: 8] = k[8*i +: 8];
      end
    end
    return res;
  endfunction

endpackage

[hdl/name_to_handle_table_core.sv]
// Top level of the name-to-handle table: request sequencer, scan unit, output register and storage.
//
// Requests arrive as words on the in_ stream: add, remove or lookup of an
// eight-byte name. Each request gives exactly one result word on the out_
// stream: ok, the entry index and, on a lookup hit, the stored handle.
// Names are cut at their first zero byte before they are stored or compared.
// Every request scans the whole table through the single read port of the
// RAM, one entry per cycle; the next request is taken only once the result
// of the current one has been loaded into the output register.
// A successful add or remove writes the chosen entry back once the scan ends.
// The result sits in an output register; a new request may be accepted
// while it waits, but that request's write-back and result hold until the
// receiver has taken the previous word.
// After reset the block clears the valid mark of every entry, one entry per
// cycle; in_tready stays low during that pass.
module name_to_handle_table_core #(
  parameter int TABLE_DEPTH = ntht_pkg::DEF_TABLE_DEPTH,
  parameter int HANDLE_BITS = ntht_pkg::DEF_HANDLE_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // kind [1:0], key_name [65:2], conn_handle [73:66], zero fill above
  input  logic [ntht_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // ok [0], slot [7:1], found_handle [15:8]
  output logic [ntht_pkg::OUT_TDATA_W-1:0]    out_tdata
);
  import ntht_pkg::*;

  localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W  = ADDR_W + 1;
  localparam int WORD_W = 1 + HANDLE_BITS + KEY_W;
  localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(TABLE_DEPTH - 1);
  localparam logic [CNT_W-1:0]  DEPTH_CNT = CNT_W'(TABLE_DEPTH);

  localparam logic [1:0] ST_CLEAR  = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_SCAN   = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0]             state_r, state_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   cmp_vld_r;
  logic [ADDR_W-1:0]      cmp_idx_r;
  logic [KIND_W-1:0]      req_kind_r;
  logic [KEY_W-1:0]       req_key_r;
  logic [HANDLE_BITS-1:0] req_handle_r;

  logic                   out_valid_r, out_valid_nxt;
  logic                   out_ok_r;
  logic [SLOT_W-1:0]      out_slot_r;
  logic [OUT_HANDLE_W-1:0] out_handle_r;

  logic                   in_acc;
  logic                   rd_en;
  logic                   wr_en;
  logic [ADDR_W-1:0]      wr_addr;
  logic [WORD_W-1:0]      wr_data;
  logic [WORD_W-1:0]      rd_data;
  logic                   out_free;
  logic                   finish_go;

  scan_flags_t            flags;
  logic [ADDR_W-1:0]      hit_idx;
  logic [HANDLE_BITS-1:0] hit_handle;
  logic [ADDR_W-1:0]      free_idx;

  logic                   res_ok;
  logic [ADDR_W-1:0]      res_idx;
  logic [HANDLE_BITS-1:0] res_handle;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign finish_go = (state_r == ST_FINISH) && out_free;
  assign rd_en     = (state_r == ST_SCAN) && (cnt_r < DEPTH_CNT);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_CLEAR: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r[ADDR_W-1:0] == LAST_IDX) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_SCAN;
          cnt_nxt   = '0;
        end
      end
      ST_SCAN: begin
        if (rd_en) begin
          cnt_nxt = cnt_r + 1'b1;
        end
        // The last entry's compare result is in the scan unit next cycle.
        if (cmp_vld_r && cmp_idx_r == LAST_IDX) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
        cnt_nxt   = '0;
      end
    endcase
  end

  // Outcome of the finished scan.
  always_comb begin
    res_ok     = 1'b0;
    res_idx    = '0;
    res_handle = '0;
    case (req_kind_r)
      KIND_ADD: begin
        if (!flags.hit_found && flags.free_found) begin
          res_ok  = 1'b1;
          res_idx = free_idx;
        end
      end
      KIND_REMOVE: begin
        if (flags.hit_found) begin
          res_ok  = 1'b1;
          res_idx = hit_idx;
        end
      end
      KIND_LOOKUP: begin
        if (flags.hit_found) begin
          res_ok     = 1'b1;
          res_idx    = hit_idx;
          res_handle = hit_handle;
        end
      end
      default: begin
        res_ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cnt_r[ADDR_W-1:0];
    wr_data = '0;
    if (state_r == ST_CLEAR) begin
      wr_en = 1'b1;
    end else if (finish_go && res_ok && req_kind_r == KIND_ADD) begin
      wr_en   = 1'b1;
      wr_addr = free_idx;
      wr_data = {1'b1, req_handle_r, req_key_r};
    end else if (finish_go && res_ok && req_kind_r == KIND_REMOVE) begin
      wr_en   = 1'b1;
      wr_addr = hit_idx;
      wr_data = {1'b0, hit_handle, req_key_r};
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (finish_go) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cnt_r       <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      cmp_vld_r   <= rd_en;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r <= cnt_r[ADDR_W-1:0];
    if (in_acc) begin
      req_kind_r   <= in_tdata[KIND_W-1:0];
      req_key_r    <= norm_key(in_tdata[KIND_W +: KEY_W]);
      req_handle_r <= HANDLE_BITS'(in_tdata[KIND_W+KEY_W +: IN_HANDLE_W]);
    end
    if (finish_go) begin
      out_ok_r     <= res_ok;
      out_slot_r   <= SLOT_W'(res_idx);
      out_handle_r <= OUT_HANDLE_W'(res_handle);
    end
  end

  ntht_mem #(
    .DEPTH  (TABLE_DEPTH),
    .WIDTH  (WORD_W),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (cnt_r[ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  ntht_scan #(
    .ADDR_W      (ADDR_W),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (in_acc),
    .ent_vld    (cmp_vld_r),
    .ent_idx    (cmp_idx_r),
    .ent_valid  (rd_data[WORD_W-1]),
    .ent_key    (rd_data[KEY_W-1:0]),
    .ent_handle (rd_data[KEY_W +: HANDLE_BITS]),
    .req_key    (req_key_r),
    .flags      (flags),
    .hit_idx    (hit_idx),
    .hit_handle (hit_handle),
    .free_idx   (free_idx)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_handle_r, out_slot_r, out_ok_r};

endmodule

[hdl/ntht_mem.sv]
// Table storage: one synchronous RAM, one write port and one registered read port.
module ntht_mem #(
  parameter int DEPTH  = 128,
  parameter int WIDTH  = 73,
  parameter int ADDR_W = 7
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[hdl/ntht_scan.sv]
// Scan unit: compares each entry read from the table and keeps the first hit and first free entry.
module ntht_scan #(
  parameter int ADDR_W      = 7,
  parameter int HANDLE_BITS = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic                    ent_vld,
  input  logic [ADDR_W-1:0]       ent_idx,
  input  logic                    ent_valid,
  input  logic [ntht_pkg::KEY_W-1:0] ent_key,
  input  logic [HANDLE_BITS-1:0]  ent_handle,
  input  logic [ntht_pkg::KEY_W-1:0] req_key,
  output ntht_pkg::scan_flags_t   flags,
  output logic [ADDR_W-1:0]       hit_idx,
  output logic [HANDLE_BITS-1:0]  hit_handle,
  output logic [ADDR_W-1:0]       free_idx
);
  import ntht_pkg::*;

  scan_flags_t            flags_r, flags_nxt;
  logic [ADDR_W-1:0]      hit_idx_r, hit_idx_nxt;
  logic [HANDLE_BITS-1:0] hit_handle_r, hit_handle_nxt;
  logic [ADDR_W-1:0]      free_idx_r, free_idx_nxt;

  always_comb begin
    flags_nxt      = flags_r;
    hit_idx_nxt    = hit_idx_r;
    hit_handle_nxt = hit_handle_r;
    free_idx_nxt   = free_idx_r;
    if (start) begin
      flags_nxt = '0;
    end else if (ent_vld) begin
      // Entries arrive in ascending order, so the first one seen is the lowest.
      if (ent_valid && ent_key == req_key && !flags_r.hit_found) begin
        flags_nxt.hit_found = 1'b1;
        hit_idx_nxt         = ent_idx;
        hit_handle_nxt      = ent_handle;
      end
      if (!ent_valid && !flags_r.free_found) begin
        flags_nxt.free_found = 1'b1;
        free_idx_nxt         = ent_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
    end else begin
      flags_r <= flags_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hit_idx_r    <= hit_idx_nxt;
    hit_handle_r <= hit_handle_nxt;
    free_idx_r   <= free_idx_nxt;
  end

  assign flags      = flags_r;
  assign hit_idx    = hit_idx_r;
  assign hit_handle = hit_handle_r;
  assign free_idx   = free_idx_r;

endmodule

[dv/tb_name_to_handle_table_core.sv]
// Testbench for name_to_handle_table_core: random and directed requests checked against a mirror.
module tb_name_to_handle_table_core;
  timeunit 1ns;
  timeprecision 1ps;

  import ntht_pkg::*;

  localparam int TABLE_DEPTH = DEF_TABLE_DEPTH;
  localparam int POOL_SIZE = 192;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  // Laid out like out_tdata, lowest field last.
  typedef struct packed {
    logic [OUT_HANDLE_W-1:0] found_handle;
    logic [SLOT_W-1:0]       slot;
    logic                    ok;
  } answer_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;

  // Mirror of the table contents, updated as each request word is accepted.
  logic                   mirror_valid [TABLE_DEPTH];
  logic [KEY_W-1:0]       mirror_key [TABLE_DEPTH];
  logic [IN_HANDLE_W-1:0] mirror_handle [TABLE_DEPTH];

  answer_t          answer_q[$];
  logic [KEY_W-1:0] name_pool [POOL_SIZE];
  int               error_count = 0;
  int               valid_idle_pct = 0;
  int               ready_idle_pct = 0;
  int               stall_hold_cycles = 0;

  name_to_handle_table_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Keep the name up to its first zero byte and clear everything above it.
  function automatic logic [KEY_W-1:0] trim_name(input logic [KEY_W-1:0] raw);
    logic [KEY_W-1:0] name;
    int               n;
    name = '0;
    n = 0;
    while (n < 8 && raw[8*n +: 8] != 8'd0) begin
      name[8*n +: 8] = raw[8*n +: 8];
      n++;
    end
    return name;
  endfunction

  // Half of the time, fill the bytes behind the terminator with junk.
  function automatic logic [KEY_W-1:0] pad_after_terminator(input logic [KEY_W-1:0] name);
    logic [KEY_W-1:0] raw;
    int               n;
    raw = name;
    n = 0;
    while (n < 8 && name[8*n +: 8] != 8'd0) n++;
    if (n < 7 && $urandom_range(1) == 1) begin
      for (int b = n + 1; b < 8; b++) raw[8*b +: 8] = 8'($urandom_range(255));
    end
    return raw;
  endfunction

  function automatic answer_t apply_request(input logic [KIND_W-1:0] kind,
                                            input logic [KEY_W-1:0] raw_key,
                                            input logic [IN_HANDLE_W-1:0] handle);
    answer_t          ans;
    logic [KEY_W-1:0] name;
    int               hit;
    int               free_slot;
    ans = '0;
    name = trim_name(raw_key);
    hit = -1;
    free_slot = -1;
    // Scan downward so that the lowest matching and lowest free entries win.
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (mirror_valid[i] && mirror_key[i] == name) hit = i;
      if (!mirror_valid[i]) free_slot = i;
    end
    case (kind)
      KIND_ADD: begin
        if (hit < 0 && free_slot >= 0) begin
          mirror_valid[free_slot] = 1'b1;
          mirror_key[free_slot] = name;
          mirror_handle[free_slot] = handle;
          ans.ok = 1'b1;
          ans.slot = SLOT_W'(free_slot);
        end
      end
      KIND_REMOVE: begin
        if (hit >= 0) begin
          mirror_valid[hit] = 1'b0;
          ans.ok = 1'b1;
          ans.slot = SLOT_W'(hit);
        end
      end
      KIND_LOOKUP: begin
        if (hit >= 0) begin
          ans.ok = 1'b1;
          ans.slot = SLOT_W'(hit);
          ans.found_handle = OUT_HANDLE_W'(mirror_handle[hit]);
        end
      end
      default: begin
      end
    endcase
    return ans;
  endfunction

  task automatic send_request(input logic [KIND_W-1:0] kind, input logic [KEY_W-1:0] key,
                              input logic [IN_HANDLE_W-1:0] handle);
    int gap;
    if ($urandom_range(99) < valid_idle_pct) begin
      gap = $urandom_range(1, 150);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {{(IN_TDATA_W - KIND_W - KEY_W - IN_HANDLE_W){1'b0}}, handle, key, kind};
    do @(posedge clk); while (!in_tready);
    answer_q.push_back(apply_request(kind, key, handle));
  endtask

  task automatic test_directed_cases();
    send_request(KIND_LOOKUP, 64'h41, 8'h11);
    send_request(KIND_REMOVE, 64'h41, 8'h00);
    send_request(KIND_ADD, '1, 8'hFF);
    send_request(KIND_ADD, 64'h4241, 8'h00);
    // The empty name is a legal key.
    send_request(KIND_ADD, 64'h0, 8'h5A);
    send_request(KIND_LOOKUP, 64'hFFFF_FFFF_FFFF_FF00, 8'h00);
    send_request(KIND_ADD, 64'hDEAD_BEEF_CA00_4241, 8'h33);
    send_request(KIND_LOOKUP, 64'h1234_5678_9A00_4241, 8'hFF);
    send_request(KIND_LOOKUP, '1, 8'h00);
    send_request(KIND_UNUSED, '1, 8'hFF);
    send_request(KIND_REMOVE, '1, 8'hC3);
    send_request(KIND_LOOKUP, '1, 8'h00);
    send_request(KIND_ADD, 64'h51, 8'hA5);
    send_request(KIND_REMOVE, 64'h4241, 8'h00);
    send_request(KIND_REMOVE, 64'h4241, 8'h00);
    send_request(KIND_ADD, 64'h0102_0304_0506_0708, 8'h7E);
    send_request(KIND_LOOKUP, 64'h0102_0304_0506_0708, 8'h00);
    send_request(KIND_LOOKUP, 64'h0202_0304_0506_0708, 8'h00);
    send_request(KIND_UNUSED, 64'h0, 8'h00);
    send_request(KIND_REMOVE, 64'h00AA_0000, 8'h00);
    send_request(KIND_REMOVE, 64'h51, 8'h00);
    send_request(KIND_REMOVE, 64'h0102_0304_0506_0708, 8'h00);
  endtask

  // Fill every entry, try to overflow, then punch holes and refill them.
  task automatic test_fill_and_overflow();
    for (int i = 0; i < TABLE_DEPTH + 4; i++) begin
      send_request(KIND_ADD, pad_after_terminator(name_pool[i]), 8'($urandom_range(255)));
    end
    for (int i = 0; i < 16; i++) begin
      send_request(KIND_LOOKUP, pad_after_terminator(name_pool[$urandom_range(TABLE_DEPTH + 3)]),
                   8'($urandom_range(255)));
    end
    for (int i = 0; i < 64; i++) begin
      send_request(KIND_REMOVE, pad_after_terminator(name_pool[$urandom_range(TABLE_DEPTH - 1)]),
                   8'($urandom_range(255)));
    end
    for (int i = TABLE_DEPTH; i < POOL_SIZE; i++) begin
      send_request(KIND_ADD, pad_after_terminator(name_pool[i]), 8'($urandom_range(255)));
    end
  endtask

  task automatic test_random_requests(input int count);
    logic [KIND_W-1:0] kind;
    logic [KEY_W-1:0]  key;
    int                pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 40) kind = KIND_ADD;
      else if (pick < 65) kind = KIND_REMOVE;
      else if (pick < 95) kind = KIND_LOOKUP;
      else kind = KIND_UNUSED;
      if ($urandom_range(9) == 0) key = {$urandom, $urandom};
      else key = pad_after_terminator(name_pool[$urandom_range(POOL_SIZE - 1)]);
      send_request(kind, key, 8'($urandom_range(255)));
    end
  endtask

  // The receiver stops for a long time while requests keep coming.
  task automatic test_output_backpressure();
    stall_hold_cycles = 1000;
    for (int n = 0; n < 6; n++) begin
      send_request($urandom_range(1) ? KIND_LOOKUP : KIND_ADD,
                   pad_after_terminator(name_pool[$urandom_range(POOL_SIZE - 1)]),
                   8'($urandom_range(255)));
    end
  endtask

  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_hold_cycles != 0) begin
        out_tready <= 1'b0;
        for (int n = 1; n < stall_hold_cycles; n++) @(posedge clk);
        stall_hold_cycles = 0;
      end else begin
        out_tready <= ($urandom_range(99) >= ready_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    answer_t got;
    answer_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = answer_t'(out_tdata);
      if (answer_q.size() == 0) begin
        $error("result word 0x%0h arrived with no request waiting", out_tdata);
        error_count++;
      end else begin
        want = answer_q.pop_front();
        if (got.ok !== want.ok) begin
          $error("ok: expected %0d, actual %0d", want.ok, got.ok);
          error_count++;
        end
        if (got.slot !== want.slot) begin
          $error("slot: expected %0d, actual %0d", want.slot, got.slot);
          error_count++;
        end
        if (got.found_handle !== want.found_handle) begin
          $error("found_handle: expected 0x%0h, actual 0x%0h", want.found_handle,
                 got.found_handle);
          error_count++;
        end
      end
    end
  end

  initial begin
    #30ms;
    $display("tb: failure");
    $finish;
  end

  initial begin
    int len;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      mirror_valid[i] = 1'b0;
      mirror_key[i] = '0;
      mirror_handle[i] = '0;
    end
    // Names of one to eight nonzero characters.
    for (int i = 0; i < POOL_SIZE; i++) begin
      name_pool[i] = '0;
      len = $urandom_range(1, 8);
      for (int b = 0; b < len; b++) name_pool[i][8*b +: 8] = 8'($urandom_range(1, 255));
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    valid_idle_pct = 30;
    ready_idle_pct = 51;
    test_directed_cases();
    test_fill_and_overflow();
    test_random_requests(540);
    valid_idle_pct = 51;
    ready_idle_pct = 30;
    test_random_requests(540);
    test_output_backpressure();
    valid_idle_pct = 0;
    ready_idle_pct = 0;
    test_random_requests(540);

    in_tvalid <= 1'b0;
    while (answer_q.size() != 0) @(posedge clk);
    repeat (TABLE_DEPTH + 8) @(posedge clk);
    if (answer_q.size() != 0) begin
      $error("%0d results never arrived", answer_q.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[files.f]
hdl/ntht_pkg.sv
hdl/ntht_mem.sv
hdl/ntht_scan.sv
hdl/name_to_handle_table_core.sv
dv/tb_name_to_handle_table_core.sv
